// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

// ===== src/lpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfc_pkg
// types, constants and header helpers of the length prefixed frame checker
// ----------------------------------------------------------------------------
package lpfc_pkg;

  localparam int unsigned MagicLen = 11;
  localparam int unsigned HexDigits = 8;
  localparam int unsigned HdrTotal = MagicLen + HexDigits + 1;
  localparam int unsigned CountW = 22;
  localparam int unsigned LenW = 32;
  localparam int unsigned LimitW = 22;

  localparam logic [LimitW-1:0] LIMIT_CAP = LimitW'(2 * 1024 * 1024);
  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [7:0] NEWLINE = 8'h0a;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  localparam logic [0:0] REG_MAX_PAYLOAD = 1'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              out_valid;
    logic              frame_done;
    logic [1:0]        status;
    logic [LimitW-1:0] payload_length;
  } out_item_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h41;
      4'd1:    b = 8'h53;
      4'd2:    b = 8'h43;
      4'd3:    b = 8'h53;
      4'd4:    b = 8'h54;
      4'd5:    b = 8'h55;
      4'd6:    b = 8'h44;
      4'd7:    b = 8'h49;
      4'd8:    b = 8'h4f;
      4'd9:    b = 8'h31;
      4'd10:   b = 8'h3a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // bit 4 set for a byte that is not a lowercase hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

// ===== src/lpfc_core.sv =====
// ----------------------------------------------------------------------------
// lpfc_core
// frame state and per-byte header check, verdict on the last byte
// ----------------------------------------------------------------------------
module lpfc_core
  import lpfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  in_item_t          item,
  input  logic [LimitW-1:0] max_payload,
  output out_item_t         result
);

  logic [CountW-1:0] count_r, count_nxt;
  logic [LenW-1:0]   dlen_r, dlen_nxt;
  logic              ferr_r, ferr_nxt;

  logic [CountW-1:0] count_inc;
  logic [LimitW-1:0] limit;
  logic [4:0]        nib;
  logic              payload;
  logic [1:0]        status;
  logic [CountW:0]   hdr_plus_limit;
  logic [LenW:0]     hdr_plus_dlen;

  assign limit = (max_payload > LIMIT_CAP) ? LIMIT_CAP : max_payload;
  assign nib = hex_nibble(item.in_byte);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign hdr_plus_limit = (CountW + 1)'(HdrTotal) + {1'b0, limit};

  always_comb begin
    ferr_nxt = ferr_r;
    dlen_nxt = dlen_r;
    payload = 1'b0;
    if (count_r < CountW'(MagicLen)) begin
      if (item.in_byte != magic_byte(count_r[3:0])) ferr_nxt = 1'b1;
    end else if (count_r < CountW'(MagicLen + HexDigits)) begin
      if (nib[4]) begin
        ferr_nxt = 1'b1;
      end else begin
        dlen_nxt = {dlen_r[LenW-5:0], nib[3:0]};
      end
    end else if (count_r == CountW'(HdrTotal - 1)) begin
      if (item.in_byte != NEWLINE) ferr_nxt = 1'b1;
    end else begin
      payload = 1'b1;
    end
  end

  assign hdr_plus_dlen = (LenW + 1)'(HdrTotal) + {1'b0, dlen_nxt};

  always_comb begin
    if ({1'b0, count_inc} > hdr_plus_limit) begin
      status = STATUS_TOO_BIG;
    end else if (count_inc < CountW'(HdrTotal) || ferr_nxt) begin
      status = STATUS_INVALID;
    end else if (dlen_nxt > LenW'(limit)) begin
      status = STATUS_TOO_BIG;
    end else if (dlen_nxt == '0 || (LenW + 1)'(count_inc) != hdr_plus_dlen) begin
      status = STATUS_INVALID;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result.out_byte = payload ? item.in_byte : 8'h00;
    result.out_valid = payload;
    result.frame_done = item.last_byte;
    result.status = item.last_byte ? status : STATUS_OK;
    result.payload_length = (item.last_byte && status == STATUS_OK) ?
                            dlen_nxt[LimitW-1:0] : '0;
  end

  assign count_nxt = item.last_byte ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dlen_r <= '0;
      ferr_r <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      dlen_r <= item.last_byte ? '0 : dlen_nxt;
      ferr_r <= item.last_byte ? 1'b0 : ferr_nxt;
    end
  end

endmodule

// ===== src/length_prefixed_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_unit
// checks an 11-byte magic, 8 hex length digits and a newline, passes payload
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_data (in_item_t)
//   out      output     out_valid / out_stall out_data (out_item_t)
//   cfg      input      apb write / read      max_payload at address 0
//
// one byte per cycle sustained while out_stall is low; each byte passes the input register, then the result register
// the header check and verdict sit between the input and result registers
// synchronous active-low reset clears the frame state, max_payload to 2097152
// a stalled result holds; input is taken when the input register is empty or the result stage can move
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module length_prefixed_frame_checker_unit
  import lpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              s1_v_r, s1_v_nxt;
  in_item_t          s1_item_r;
  logic              s2_v_r, s2_v_nxt;
  out_item_t         s2_item_r;
  out_item_t         core_res;
  logic [LimitW-1:0] max_payload_r;
  logic              advance;
  logic              in_take;

  assign advance = s1_v_r && (!s2_v_r || !out_stall);
  assign in_stall = s1_v_r && !advance;
  assign in_take = in_valid && !in_stall;

  assign s1_v_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_v_r);
  assign s2_v_nxt = advance ? 1'b1 : (out_stall ? s2_v_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_data;
    if (advance) s2_item_r <= core_res;
  end

  lpfc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (s1_item_r),
    .max_payload (max_payload_r),
    .result      (core_res)
  );

  assign out_valid = s2_v_r;
  assign out_data = s2_item_r;

  // config register
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= LIMIT_CAP;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MAX_PAYLOAD) begin
      max_payload_r <= cfg_pwdata[LimitW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MAX_PAYLOAD) cfg_prdata = 32'(max_payload_r);
  end

  `CHK_IMPLY(a_stall_only_when_full, in_stall, s1_v_r && s2_v_r && out_stall)
  `CHK_NEXT(a_held_item_kept, in_stall, s1_v_r)
  `CHK_IMPLY(a_status_only_on_done, out_valid && !out_data.frame_done, out_data.status == STATUS_OK && out_data.payload_length == '0)
  `CHK_IMPLY(a_no_length_on_error, out_valid && out_data.status != STATUS_OK, out_data.payload_length == '0)

endmodule

// ===== dv/length_prefixed_frame_checker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_unit_tb
// self-checking bench for the length prefixed frame checker
//
// drives framed byte streams: well-formed frames, header faults, truncated,
// oversized and zero-length frames, and random noise. max_payload is changed
// between phases, only while the block is drained. A predictor tracks the frame
// state per accepted byte and queues the expected result. Every result
// transfer is compared field by field against that queue. Idling on both
// channels varies by phase, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_unit_tb;
  import lpfc_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldCycles = 120;
  localparam logic [8*MagicLen-1:0] PREFIX_BYTES = 88'h41_53_43_53_54_55_44_49_4f_31_3a;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // frame tracking state of the predictor
  logic [CountW-1:0] frame_pos = '0;
  logic [LenW-1:0]   length_acc = '0;
  logic              header_bad = 1'b0;
  logic [LimitW-1:0] limit_reg = LIMIT_CAP;

  out_item_t  frame_outcomes[$];
  out_item_t  wanted;
  logic [7:0] frame_buf[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;

  length_prefixed_frame_checker_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic out_item_t judge_byte(input in_item_t item);
    out_item_t         res;
    logic [7:0]        c;
    logic [3:0]        digit;
    logic              digit_ok;
    logic [LimitW-1:0] eff_limit;
    res = '0;
    c = item.in_byte;
    digit = 4'd0;
    digit_ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = c[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      digit = c[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
    if (frame_pos < MagicLen) begin
      if (c != PREFIX_BYTES[8*(MagicLen-1-int'(frame_pos)) +: 8]) header_bad = 1'b1;
    end else if (frame_pos < MagicLen + HexDigits) begin
      if (!digit_ok) begin
        header_bad = 1'b1;
      end else begin
        length_acc = {length_acc[LenW-5:0], digit};
      end
    end else if (frame_pos == HdrTotal - 1) begin
      if (c != NEWLINE) header_bad = 1'b1;
    end else begin
      res.out_valid = 1'b1;
      res.out_byte = c;
    end
    if (frame_pos != COUNT_MAX) frame_pos = frame_pos + 1'b1;
    if (item.last_byte) begin
      res.frame_done = 1'b1;
      eff_limit = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
      if (frame_pos > HdrTotal + eff_limit) begin
        res.status = STATUS_TOO_BIG;
      end else if (frame_pos < HdrTotal || header_bad) begin
        res.status = STATUS_INVALID;
      end else if (length_acc > eff_limit) begin
        res.status = STATUS_TOO_BIG;
      end else if (length_acc == 0 || frame_pos != HdrTotal + length_acc) begin
        res.status = STATUS_INVALID;
      end else begin
        res.status = STATUS_OK;
        res.payload_length = length_acc[LimitW-1:0];
      end
      frame_pos = '0;
      length_acc = '0;
      header_bad = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d: %s is %0h, predicted %0h", results_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    in_item_t item;
    item.in_byte = value;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    frame_outcomes.push_back(judge_byte(item));
    bytes_sent++;
    if (last) frames_sent++;
  endtask

  // prefix, lowercase hex length, newline, random body; optional fault and cut
  task automatic send_frame(input logic [LenW-1:0] declared, input int unsigned body_len,
                            input int fault_pos = -1, input logic [7:0] fault_val = 8'h00,
                            input int unsigned keep = 0);
    logic [3:0] d;
    frame_buf = {};
    for (int k = 0; k < MagicLen; k++) begin
      frame_buf.push_back(PREFIX_BYTES[8*(MagicLen-1-k) +: 8]);
    end
    for (int k = HexDigits - 1; k >= 0; k--) begin
      d = declared[4*k +: 4];
      frame_buf.push_back(d < 4'd10 ? 8'h30 + d : 8'h57 + d);
    end
    frame_buf.push_back(NEWLINE);
    repeat (body_len) frame_buf.push_back(8'($urandom_range(255)));
    if (fault_pos >= 0 && fault_pos < frame_buf.size()) frame_buf[fault_pos] = fault_val;
    if (keep != 0) begin
      while (frame_buf.size() > keep) void'(frame_buf.pop_back());
    end
    foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (frame_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [LimitW-1:0] value);
    settle_idle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_MAX_PAYLOAD);
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_reg = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_well_formed();
    send_frame(32'd1, 1, 20, 8'h00);
    send_frame(32'd3, 3, 22, 8'hff);
    send_frame(32'h0000_001a, 26);
  endtask

  task automatic test_length_digits();
    send_frame(32'h0123_4567, 2);
    send_frame(32'h89ab_cdef, 0);
    send_frame(32'h0020_0000, 1);
    send_frame(32'h0020_0001, 0);
  endtask

  task automatic test_header_faults();
    send_frame(32'd2, 2, 0, 8'h61);
    send_frame(32'd2, 2, 10, 8'h3b);
    send_frame(32'd2, 2, 11, 8'h2f);
    send_frame(32'd2, 2, 12, 8'h3a);
    send_frame(32'd2, 2, 15, 8'h41);
    send_frame(32'd2, 2, 17, 8'h60);
    send_frame(32'd2, 2, 18, 8'h67);
    send_frame(32'd2, 2, 19, 8'h0d);
  endtask

  task automatic test_short_and_zero();
    send_byte(8'h41, 1'b1);
    send_frame(32'd2, 2, -1, 8'h00, 19);
    send_frame(32'd0, 0);
    send_frame(32'd0, 1);
    send_frame(32'd3, 2);
    send_frame(32'd3, 4);
  endtask

  task automatic test_limit_settings();
    write_max_payload(22'd1);
    send_frame(32'd1, 1);
    send_frame(32'd2, 2);
    send_frame(32'd2, 1);
    send_frame(32'd2, 2, 3, 8'h00);
    write_max_payload(22'd0);
    send_frame(32'd0, 0);
    send_frame(32'd1, 0);
    send_frame(32'd0, 1);
    write_max_payload('1);
    send_frame(32'd3, 3);
    send_frame(32'h0020_0001, 0);
    write_max_payload(LIMIT_CAP);
  endtask

  task automatic test_backpressure();
    write_max_payload(LIMIT_CAP);
    hold_requests++;
    send_frame(32'd8, 8);
  endtask

  task automatic test_random_frames(input int unsigned n_bytes);
    int unsigned      start;
    int unsigned      kind;
    int unsigned      len;
    logic [LenW-1:0]  declared;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      kind = $urandom_range(99);
      declared = $urandom_range(1, 12);
      if (kind < 60) begin
        send_frame(declared, declared);
      end else if (kind < 70) begin
        send_frame(declared, $urandom_range(0, 14));
      end else if (kind < 80) begin
        send_frame(declared, declared, $urandom_range(19), 8'($urandom_range(255)));
      end else if (kind < 88) begin
        send_frame(declared, declared, -1, 8'h00, $urandom_range(1, 19));
      end else if (kind < 94) begin
        send_frame($urandom, $urandom_range(0, 6));
      end else begin
        len = $urandom_range(1, 30);
        repeat (len - 1) send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  // receiver stall, with counted hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (frame_outcomes.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(out_data), 64'd0);
      end else begin
        wanted = frame_outcomes.pop_front();
        if (out_data.out_byte != wanted.out_byte) begin
          report_mismatch("out_byte", out_data.out_byte, wanted.out_byte);
        end
        if (out_data.out_valid != wanted.out_valid) begin
          report_mismatch("out_valid", out_data.out_valid, wanted.out_valid);
        end
        if (out_data.frame_done != wanted.frame_done) begin
          report_mismatch("frame_done", out_data.frame_done, wanted.frame_done);
        end
        if (out_data.status != wanted.status) begin
          report_mismatch("status", out_data.status, wanted.status);
        end
        if (out_data.payload_length != wanted.payload_length) begin
          report_mismatch("payload_length", out_data.payload_length, wanted.payload_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 49;
    test_well_formed();
    test_length_digits();
    test_header_faults();
    test_short_and_zero();

    send_idle_pct = 49;
    recv_idle_pct = 15;
    test_limit_settings();
    write_max_payload(22'($urandom_range(LIMIT_CAP + 1, 22'h3f_ffff)));
    test_random_frames(20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();

    settle_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes in %0d frames, %0d result transfers compared",
             bytes_sent, frames_sent, results_checked);
    $display("limits 0, 1, cap and above cap, header faults, short frames, long output hold");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/lpfc_pkg.sv
src/lpfc_core.sv
src/length_prefixed_frame_checker_unit.sv
dv/length_prefixed_frame_checker_unit_tb.sv
